// ===== rtl/mgm_pkg.sv =====
// Package for the gain mixer: channel count, default widths, register indexes and lane control.
`default_nettype none
package mgm_pkg;

   // Channel count is fixed by the per-channel sample ports.
   localparam int MGM_NUM_CHANNELS   = 4;
   localparam int MGM_SAMPLE_BITS    = 16;
   localparam int MGM_GAIN_FRAC_BITS = 8;

   // Register file: one gain per channel, then the active mask.
   localparam int MGM_CSR_INDEX_BITS = $clog2(MGM_NUM_CHANNELS + 1);

   localparam logic [MGM_CSR_INDEX_BITS-1:0] MGM_REG_GAIN_0      = 3'd0;
   localparam logic [MGM_CSR_INDEX_BITS-1:0] MGM_REG_GAIN_1      = 3'd1;
   localparam logic [MGM_CSR_INDEX_BITS-1:0] MGM_REG_GAIN_2      = 3'd2;
   localparam logic [MGM_CSR_INDEX_BITS-1:0] MGM_REG_GAIN_3      = 3'd3;
   localparam logic [MGM_CSR_INDEX_BITS-1:0] MGM_REG_ACTIVE_MASK = 3'd4;

   // Control that the top level hands to each lane.
   typedef struct packed {
      logic load;
      logic active;
   } mgm_lane_ctrl_type;

endpackage
`default_nettype wire

// ===== rtl/multichannel_gain_mixer_top.sv =====
// Top level of the four-channel saturating gain mixer.
`default_nettype none
// The mixer accepts one request per clock cycle while req_stall is low and
// delivers one mixed sample for each. The per-channel lanes multiply each
// sample by its Q gain and register the term; the merge stage then adds the
// active terms in channel order with saturation after every addition and
// holds the result in the output register. A request is still taken while a
// result waits, as long as the lane stage is empty. Gains above unity are
// stored as unity; writes to unknown register indexes are dropped. Registers
// should only be written while no request is in flight.
module multichannel_gain_mixer_top
   import mgm_pkg::*;
#(
   parameter int SAMPLE_BITS    = MGM_SAMPLE_BITS,
   parameter int GAIN_FRAC_BITS = MGM_GAIN_FRAC_BITS,
   localparam int CsrDataBits   = (GAIN_FRAC_BITS + 1 > MGM_NUM_CHANNELS) ?
                                  GAIN_FRAC_BITS + 1 : MGM_NUM_CHANNELS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // Request channel
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic signed [SAMPLE_BITS-1:0] req_channel_0_sample,
   input  wire logic signed [SAMPLE_BITS-1:0] req_channel_1_sample,
   input  wire logic signed [SAMPLE_BITS-1:0] req_channel_2_sample,
   input  wire logic signed [SAMPLE_BITS-1:0] req_channel_3_sample,
   input  wire logic                          req_end_of_block,
   // Result channel
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic signed [SAMPLE_BITS-1:0] rsp_mixed_sample,
   output      logic                          rsp_block_end,
   // Register write port
   input  wire logic                          csr_write_en,
   input  wire logic [MGM_CSR_INDEX_BITS-1:0] csr_index,
   input  wire logic [CsrDataBits-1:0]        csr_wdata
);

   localparam logic [GAIN_FRAC_BITS:0] GainUnity = {1'b1, {GAIN_FRAC_BITS{1'b0}}};

   logic [GAIN_FRAC_BITS:0]       gain_ff [MGM_NUM_CHANNELS];
   logic [GAIN_FRAC_BITS:0]       gain_wr;
   logic [MGM_NUM_CHANNELS-1:0]   active_mask_ff;

   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   logic                          s1_eob_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic                          rsp_hold;
   logic                          s1_open;
   logic                          req_take;

   logic signed [SAMPLE_BITS-1:0] samples [MGM_NUM_CHANNELS];
   logic signed [SAMPLE_BITS-1:0] terms   [MGM_NUM_CHANNELS];
   mgm_lane_ctrl_type             lane_ctrl [MGM_NUM_CHANNELS];

   // Gain write value, capped at unity.
   assign gain_wr = (csr_wdata[GAIN_FRAC_BITS:0] > GainUnity) ?
                    GainUnity : csr_wdata[GAIN_FRAC_BITS:0];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MGM_NUM_CHANNELS; i++) begin
            gain_ff[i] <= GainUnity;
         end
         active_mask_ff <= '0;
      end else if (csr_write_en) begin
         case (csr_index)
            MGM_REG_GAIN_0:      gain_ff[0] <= gain_wr;
            MGM_REG_GAIN_1:      gain_ff[1] <= gain_wr;
            MGM_REG_GAIN_2:      gain_ff[2] <= gain_wr;
            MGM_REG_GAIN_3:      gain_ff[3] <= gain_wr;
            MGM_REG_ACTIVE_MASK: active_mask_ff <= csr_wdata[MGM_NUM_CHANNELS-1:0];
            default: ;
         endcase
      end
   end

   // Pipeline flow: the output register holds while stalled, and the lane
   // stage may load whenever it is empty or its contents move on.
   always_comb begin
      rsp_hold     = rsp_valid_ff && rsp_stall;
      s1_open      = !s1_valid_ff || !rsp_hold;
      req_take     = req_valid && s1_open;
      s1_valid_in  = s1_open ? req_valid : s1_valid_ff;
      rsp_valid_in = rsp_hold ? 1'b1 : s1_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // End-of-block flag travels beside the lane terms.
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_eob_ff <= req_end_of_block;
      end
   end

   assign samples[0] = req_channel_0_sample;
   assign samples[1] = req_channel_1_sample;
   assign samples[2] = req_channel_2_sample;
   assign samples[3] = req_channel_3_sample;

   // One lane per channel.
   for (genvar g = 0; g < MGM_NUM_CHANNELS; g++) begin : g_lane
      assign lane_ctrl[g].load   = req_take;
      assign lane_ctrl[g].active = active_mask_ff[g];

      mgm_lane #(
         .SAMPLE_BITS    (SAMPLE_BITS),
         .GAIN_FRAC_BITS (GAIN_FRAC_BITS)
      ) u_lane (
         .clock  (clock),
         .ctrl   (lane_ctrl[g]),
         .sample (samples[g]),
         .gain   (gain_ff[g]),
         .term   (terms[g])
      );
   end

   // Saturating merge and output register.
   mgm_merge #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_merge (
      .clock        (clock),
      .load         (!rsp_hold),
      .terms        (terms),
      .end_of_block (s1_eob_ff),
      .mixed_sample (rsp_mixed_sample),
      .block_end    (rsp_block_end)
   );

   assign req_stall = s1_valid_ff && rsp_hold;
   assign rsp_valid = rsp_valid_ff;

   // A request is only held off while the lane stage is occupied.
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> s1_valid_ff)
      else $error("request stalled with an empty lane stage");

   // A new result only appears when the lane stage held a request.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(s1_valid_ff))
      else $error("result appeared without a request in the lanes");

   // All-zero lane terms always mix to zero.
   assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !rsp_hold && terms[0] == '0 && terms[1] == '0 &&
       terms[2] == '0 && terms[3] == '0) |=> (rsp_mixed_sample == '0))
      else $error("zero terms produced a nonzero mix");

endmodule
`default_nettype wire

// ===== rtl/mgm_lane.sv =====
// One mixer lane: scales a channel sample by its gain (zero when inactive) and registers the term.
`default_nettype none
module mgm_lane
   import mgm_pkg::*;
#(
   parameter int SAMPLE_BITS    = MGM_SAMPLE_BITS,
   parameter int GAIN_FRAC_BITS = MGM_GAIN_FRAC_BITS
) (
   input  wire logic                             clock,
   input  wire mgm_lane_ctrl_type                ctrl,
   input  wire logic signed [SAMPLE_BITS-1:0]    sample,
   input  wire logic        [GAIN_FRAC_BITS:0]   gain,
   output      logic signed [SAMPLE_BITS-1:0]    term
);

   localparam int ProdBits = SAMPLE_BITS + GAIN_FRAC_BITS + 2;

   logic signed [ProdBits-1:0]    product;
   logic signed [ProdBits-1:0]    shifted;
   logic signed [SAMPLE_BITS-1:0] term_in;
   logic signed [SAMPLE_BITS-1:0] term_ff;

   // Signed product; the arithmetic shift floors. With gain at most unity
   // the shifted value always fits the sample width.
   always_comb begin
      product = ProdBits'(sample) * $signed({1'b0, gain});
      shifted = product >>> GAIN_FRAC_BITS;
      term_in = ctrl.active ? shifted[SAMPLE_BITS-1:0] : '0;
   end

   // Term register feeding the merge stage.
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         term_ff <= term_in;
      end
   end

   assign term = term_ff;

endmodule
`default_nettype wire

// ===== rtl/mgm_merge.sv =====
// Merge stage: saturating sum of the lane terms in channel order, registered output.
`default_nettype none
module mgm_merge
   import mgm_pkg::*;
#(
   parameter int SAMPLE_BITS = MGM_SAMPLE_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          load,
   input  wire logic signed [SAMPLE_BITS-1:0] terms [MGM_NUM_CHANNELS],
   input  wire logic                          end_of_block,
   output      logic signed [SAMPLE_BITS-1:0] mixed_sample,
   output      logic                          block_end
);

   logic signed [SAMPLE_BITS-1:0] mixed_in;
   logic signed [SAMPLE_BITS-1:0] mixed_ff;
   logic                          block_end_ff;

   // Inactive lanes carry zero, which leaves the running sum unchanged.
   // Starting from zero also reproduces the unclamped first term, since
   // every term already lies inside the sample range.
   always_comb begin
      logic signed [SAMPLE_BITS-1:0] acc;
      logic signed [SAMPLE_BITS:0]   sum;
      acc = '0;
      for (int i = 0; i < MGM_NUM_CHANNELS; i++) begin
         sum = {acc[SAMPLE_BITS-1], acc} + {terms[i][SAMPLE_BITS-1], terms[i]};
         if (sum[SAMPLE_BITS] != sum[SAMPLE_BITS-1]) begin
            // Overflow: clamp toward the sign of the true sum.
            acc = sum[SAMPLE_BITS] ? {1'b1, {(SAMPLE_BITS-1){1'b0}}}
                                   : {1'b0, {(SAMPLE_BITS-1){1'b1}}};
         end else begin
            acc = sum[SAMPLE_BITS-1:0];
         end
      end
      mixed_in = acc;
   end

   // Output register; it holds while the result waits.
   always_ff @(posedge clock) begin
      if (load) begin
         mixed_ff     <= mixed_in;
         block_end_ff <= end_of_block;
      end
   end

   assign mixed_sample = mixed_ff;
   assign block_end    = block_end_ff;

endmodule
`default_nettype wire
